@@ sv/trirot_pkg.sv @@
// trirot_pkg: shared widths, item types and the CORDIC arctangent table
// for the triangle rotation pipeline. No dependencies.

package trirot_pkg;

    localparam int COORD_BITS        = 32;   // Q16.16 coordinates
    localparam int ANGLE_BITS        = 16;   // binary angle, one turn per 2^ANGLE_BITS
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int XY_W    = 32;                // CORDIC x/y, Q2.30
    localparam int Z_W     = 32;                // residual angle, 2^32 per turn
    localparam int SUM_W   = COORD_BITS + 2;    // sum of three coordinates
    localparam int CEN_SH  = 32;                // reciprocal of three is Q0.32
    localparam int CPR_W   = SUM_W + CEN_SH;    // centroid product
    localparam int P_W     = COORD_BITS + 2;    // pivot (centroid may exceed range by one)
    localparam int D_W     = COORD_BITS + 2;    // vertex minus pivot
    localparam int RPR_W   = D_W + XY_W;        // rotation product
    localparam int FRAC_CS = 30;                // fraction bits of cos/sin

    // register stages outside the CORDIC cells: four in front, four behind
    localparam int PIPE_FIXED = 8;

    localparam logic signed [31:0]     RECIP3    = 32'sh5555_5556;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd652032874;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vert1_x;
        logic signed [COORD_BITS-1:0] vert1_y;
        logic signed [COORD_BITS-1:0] vert2_x;
        logic signed [COORD_BITS-1:0] vert2_y;
        logic signed [COORD_BITS-1:0] vert3_x;
        logic signed [COORD_BITS-1:0] vert3_y;
        logic        [ANGLE_BITS-1:0] turn_angle;
        logic                         use_pivot;
        logic signed [COORD_BITS-1:0] pivot_x;
        logic signed [COORD_BITS-1:0] pivot_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out1_x;
        logic signed [COORD_BITS-1:0] out1_y;
        logic signed [COORD_BITS-1:0] out2_x;
        logic signed [COORD_BITS-1:0] out2_y;
        logic signed [COORD_BITS-1:0] out3_x;
        logic signed [COORD_BITS-1:0] out3_y;
    } t_out;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    // per-triangle data that rides along the CORDIC cells
    typedef struct packed {
        logic [2:0][D_W-1:0]    dx;
        logic [2:0][D_W-1:0]    dy;
        logic [COORD_BITS-1:0]  px;
        logic [COORD_BITS-1:0]  py;
        t_quad                  quad;
    } t_work;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [Z_W-1:0] atan_ang(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/trirot_pivot.sv @@
// trirot_pivot: front end of the pipeline. Forms the pivot (given or
// centroid), the vertex offsets and the CORDIC start values. Uses trirot_pkg.

module trirot_pivot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  trirot_pkg::t_in     i_item,
    output logic                o_valid,
    output trirot_pkg::t_work   o_work,
    output trirot_pkg::t_cordic o_cordic
);
    import trirot_pkg::*;

    // stage A: coordinate sums
    logic                    r_a_valid;
    t_in                     r_a_item;
    logic signed [SUM_W-1:0] r_a_sx, r_a_sy;
    logic signed [SUM_W-1:0] n_a_sx, n_a_sy;
    // stage B: sums times reciprocal of three
    logic                    r_b_valid;
    t_in                     r_b_item;
    logic signed [CPR_W-1:0] r_b_cx, r_b_cy;
    logic signed [CPR_W-1:0] n_b_cx, n_b_cy;
    // stage C: pivot
    logic                    r_c_valid;
    t_in                     r_c_item;
    logic signed [P_W-1:0]   r_c_px, r_c_py;
    logic signed [P_W-1:0]   n_c_px, n_c_py;
    logic signed [CPR_W-1:0] rnd_x, rnd_y;
    // stage D: offsets and CORDIC start
    logic                    r_d_valid;
    t_work                   r_d_work;
    t_cordic                 r_d_cordic;
    t_work                   n_d_work;
    t_cordic                 n_d_cordic;

    always_comb begin
        n_a_sx = SUM_W'(i_item.vert1_x) + SUM_W'(i_item.vert2_x) + SUM_W'(i_item.vert3_x);
        n_a_sy = SUM_W'(i_item.vert1_y) + SUM_W'(i_item.vert2_y) + SUM_W'(i_item.vert3_y);
        n_b_cx = CPR_W'(r_a_sx) * CPR_W'(RECIP3);
        n_b_cy = CPR_W'(r_a_sy) * CPR_W'(RECIP3);
    end

    // round to nearest, then pick given pivot or centroid
    always_comb begin
        rnd_x  = r_b_cx + (CPR_W'(1) << (CEN_SH - 1));
        rnd_y  = r_b_cy + (CPR_W'(1) << (CEN_SH - 1));
        n_c_px = r_b_item.use_pivot ? P_W'(r_b_item.pivot_x) : rnd_x[CEN_SH +: P_W];
        n_c_py = r_b_item.use_pivot ? P_W'(r_b_item.pivot_y) : rnd_y[CEN_SH +: P_W];
    end

    always_comb begin
        n_d_work.dx[0] = D_W'(r_c_item.vert1_x) - r_c_px;
        n_d_work.dy[0] = D_W'(r_c_item.vert1_y) - r_c_py;
        n_d_work.dx[1] = D_W'(r_c_item.vert2_x) - r_c_px;
        n_d_work.dy[1] = D_W'(r_c_item.vert2_y) - r_c_py;
        n_d_work.dx[2] = D_W'(r_c_item.vert3_x) - r_c_px;
        n_d_work.dy[2] = D_W'(r_c_item.vert3_y) - r_c_py;
        n_d_work.px    = r_c_px[COORD_BITS-1:0];
        n_d_work.py    = r_c_py[COORD_BITS-1:0];
        n_d_work.quad  = t_quad'(r_c_item.turn_angle[ANGLE_BITS-1 -: 2]);
        n_d_cordic.x   = CORDIC_X0;
        n_d_cordic.y   = '0;
        n_d_cordic.z   = {2'b00, r_c_item.turn_angle[ANGLE_BITS-3:0],
                          {(Z_W - ANGLE_BITS){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_item   <= i_item;
        r_a_sx     <= n_a_sx;
        r_a_sy     <= n_a_sy;
        r_b_item   <= r_a_item;
        r_b_cx     <= n_b_cx;
        r_b_cy     <= n_b_cy;
        r_c_item   <= r_b_item;
        r_c_px     <= n_c_px;
        r_c_py     <= n_c_py;
        r_d_work   <= n_d_work;
        r_d_cordic <= n_d_cordic;
    end

    assign o_valid  = r_d_valid;
    assign o_work   = r_d_work;
    assign o_cordic = r_d_cordic;

endmodule

@@ sv/trirot_cell.sv @@
// trirot_cell: one CORDIC micro-rotation with a fixed shift, registered,
// passing the triangle data to the next cell. Uses trirot_pkg.

module trirot_cell #(
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  trirot_pkg::t_cordic i_cordic,
    input  trirot_pkg::t_work   i_work,
    output logic                o_valid,
    output trirot_pkg::t_cordic o_cordic,
    output trirot_pkg::t_work   o_work
);
    import trirot_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_ang(5'(STAGE));

    logic                   r_valid;
    t_cordic                r_cordic;
    t_work                  r_work;
    t_cordic                n_cordic;
    logic signed [XY_W-1:0] xs, ys;

    // rotate toward zero residual angle
    always_comb begin
        xs = i_cordic.x >>> STAGE;
        ys = i_cordic.y >>> STAGE;
        if (!i_cordic.z[Z_W-1]) begin
            n_cordic.x = i_cordic.x - ys;
            n_cordic.y = i_cordic.y + xs;
            n_cordic.z = i_cordic.z - ATAN;
        end else begin
            n_cordic.x = i_cordic.x + ys;
            n_cordic.y = i_cordic.y - xs;
            n_cordic.z = i_cordic.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cordic <= n_cordic;
        r_work   <= i_work;
    end

    assign o_valid  = r_valid;
    assign o_cordic = r_cordic;
    assign o_work   = r_work;

endmodule

@@ sv/trirot_rot.sv @@
// trirot_rot: back end of the pipeline. Maps the CORDIC result to cos/sin
// by quadrant, rotates the offsets, rounds and adds the pivot. Uses trirot_pkg.

module trirot_rot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  trirot_pkg::t_cordic i_cordic,
    input  trirot_pkg::t_work   i_work,
    output logic                o_valid,
    output trirot_pkg::t_out    o_result
);
    import trirot_pkg::*;

    localparam logic signed [RPR_W-1:0] RND_CS = RPR_W'(1) << (FRAC_CS - 1);

    // cos/sin stage
    logic                    r_c_valid;
    t_work                   r_c_work;
    logic signed [XY_W-1:0]  r_c_cs, r_c_sn;
    logic signed [XY_W-1:0]  n_c_cs, n_c_sn;
    // product stage
    logic                    r_p_valid;
    logic [COORD_BITS-1:0]   r_p_px, r_p_py;
    logic signed [RPR_W-1:0] r_p_xc [3];
    logic signed [RPR_W-1:0] r_p_ys [3];
    logic signed [RPR_W-1:0] r_p_xs [3];
    logic signed [RPR_W-1:0] r_p_yc [3];
    logic signed [RPR_W-1:0] n_p_xc [3];
    logic signed [RPR_W-1:0] n_p_ys [3];
    logic signed [RPR_W-1:0] n_p_xs [3];
    logic signed [RPR_W-1:0] n_p_yc [3];
    // rounding stage
    logic                    r_s_valid;
    logic [COORD_BITS-1:0]   r_s_px, r_s_py;
    logic [COORD_BITS-1:0]   r_s_rx [3];
    logic [COORD_BITS-1:0]   r_s_ry [3];
    logic [COORD_BITS-1:0]   n_s_rx [3];
    logic [COORD_BITS-1:0]   n_s_ry [3];
    logic signed [RPR_W-1:0] sum_x  [3];
    logic signed [RPR_W-1:0] sum_y  [3];
    // output stage
    logic                    r_o_valid;
    t_out                    r_o_result;
    t_out                    n_o_result;

    always_comb begin
        unique case (i_work.quad)
            QUAD_0: begin
                n_c_cs = i_cordic.x;
                n_c_sn = i_cordic.y;
            end
            QUAD_1: begin
                n_c_cs = -i_cordic.y;
                n_c_sn = i_cordic.x;
            end
            QUAD_2: begin
                n_c_cs = -i_cordic.x;
                n_c_sn = -i_cordic.y;
            end
            QUAD_3: begin
                n_c_cs = i_cordic.y;
                n_c_sn = -i_cordic.x;
            end
            default: begin
                n_c_cs = i_cordic.x;
                n_c_sn = i_cordic.y;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_p_xc[k] = RPR_W'($signed(r_c_work.dx[k])) * RPR_W'(r_c_cs);
            n_p_ys[k] = RPR_W'($signed(r_c_work.dy[k])) * RPR_W'(r_c_sn);
            n_p_xs[k] = RPR_W'($signed(r_c_work.dx[k])) * RPR_W'(r_c_sn);
            n_p_yc[k] = RPR_W'($signed(r_c_work.dy[k])) * RPR_W'(r_c_cs);
        end
    end

    // round half up, keep the wrapped coordinate bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_x[k]  = r_p_xc[k] - r_p_ys[k] + RND_CS;
            sum_y[k]  = r_p_xs[k] + r_p_yc[k] + RND_CS;
            n_s_rx[k] = sum_x[k][FRAC_CS +: COORD_BITS];
            n_s_ry[k] = sum_y[k][FRAC_CS +: COORD_BITS];
        end
    end

    always_comb begin
        n_o_result.out1_x = r_s_px + r_s_rx[0];
        n_o_result.out1_y = r_s_py + r_s_ry[0];
        n_o_result.out2_x = r_s_px + r_s_rx[1];
        n_o_result.out2_y = r_s_py + r_s_ry[1];
        n_o_result.out3_x = r_s_px + r_s_rx[2];
        n_o_result.out3_y = r_s_py + r_s_ry[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_c_valid <= i_valid;
            r_p_valid <= r_c_valid;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_work   <= i_work;
        r_c_cs     <= n_c_cs;
        r_c_sn     <= n_c_sn;
        r_p_px     <= r_c_work.px;
        r_p_py     <= r_c_work.py;
        r_p_xc     <= n_p_xc;
        r_p_ys     <= n_p_ys;
        r_p_xs     <= n_p_xs;
        r_p_yc     <= n_p_yc;
        r_s_px     <= r_p_px;
        r_s_py     <= r_p_py;
        r_s_rx     <= n_s_rx;
        r_s_ry     <= n_s_ry;
        r_o_result <= n_o_result;
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

endmodule

@@ sv/triangle_rotate_about_point_top.sv @@
// triangle_rotate_about_point_top: rotates a triangle about a pivot or its centroid.
// Stages from the accepting edge to the o_valid strobe: four front stages, one cell
//   per CORDIC step, four back stages. Throughput: one triangle per clock; every stage
//   advances each cycle.
// Reset: synchronous, active low; clears all valid bits and holds busy high, so no item
//   is taken while i_rst_n is low. Uses trirot_pkg, trirot_pivot, trirot_cell, trirot_rot.

module triangle_rotate_about_point_top #(
    parameter int CORDIC_STAGES = trirot_pkg::CORDIC_STAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  trirot_pkg::t_in  i_item,
    output logic             busy,
    output logic             o_valid,
    output trirot_pkg::t_out o_result
);
    import trirot_pkg::*;

    logic    r_busy;
    logic    accept;

    // one slot per cell boundary: slot 0 is the front end, the last feeds the back end
    logic    chain_valid  [CORDIC_STAGES+1];
    t_cordic chain_cordic [CORDIC_STAGES+1];
    t_work   chain_work   [CORDIC_STAGES+1];

    // Hold busy high through reset; afterwards the pipeline never stalls and busy drops
    // for good. The result side must take the strobe; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Front end: sums, centroid multiply, pivot select, offsets and CORDIC seed.
    trirot_pivot u_pivot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_item   (i_item),
        .o_valid  (chain_valid[0]),
        .o_work   (chain_work[0]),
        .o_cordic (chain_cordic[0])
    );

    // Row of CORDIC cells. Cell g does the micro-rotation with shift g and
    // hands its x/y/z plus the item's offsets and pivot to cell g+1.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        trirot_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (chain_valid[g]),
            .i_cordic (chain_cordic[g]),
            .i_work   (chain_work[g]),
            .o_valid  (chain_valid[g+1]),
            .o_cordic (chain_cordic[g+1]),
            .o_work   (chain_work[g+1])
        );
    end

    // Back end: quadrant fold, rotation products, rounding, pivot add.
    trirot_rot u_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[CORDIC_STAGES]),
        .i_cordic (chain_cordic[CORDIC_STAGES]),
        .i_work   (chain_work[CORDIC_STAGES]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

@@ sv/trirot_checker.sv @@
// trirot_checker: port-level assertions for triangle_rotate_about_point_top,
// attached by the bind statement at the end of this file. Uses trirot_pkg.

module trirot_checker #(
    parameter int CORDIC_STAGES = trirot_pkg::CORDIC_STAGES_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input trirot_pkg::t_in  i_item,
    input logic             busy,
    input logic             o_valid,
    input trirot_pkg::t_out o_result
);
    import trirot_pkg::*;

    localparam int LAT = PIPE_FIXED + CORDIC_STAGES;

    logic acc;
    logic on_pivot;

    assign acc      = start && !busy;
    // first vertex sits on a given pivot: it must come back unchanged
    assign on_pivot = acc && i_item.use_pivot &&
                      (i_item.vert1_x == i_item.pivot_x) &&
                      (i_item.vert1_y == i_item.pivot_y);

    a_busy_low_after_reset: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy
    ) else $error("busy high outside reset");

    a_strobe_from_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(acc, LAT)
    ) else $error("result strobe without an item accepted LAT cycles earlier");

    a_pivot_vertex_fixed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(on_pivot, LAT)) |->
            (o_result.out1_x == $past(i_item.pivot_x, LAT)) &&
            (o_result.out1_y == $past(i_item.pivot_y, LAT))
    ) else $error("vertex on pivot moved");

endmodule

bind triangle_rotate_about_point_top trirot_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_trirot_checker (.*);
